// ===== src/ppse_pkg.sv =====
// ----------------------------------------------------------------------------
// ppse_pkg
// Shared types, constants and saturation helpers for the polynomial evaluator.
// ----------------------------------------------------------------------------
package ppse_pkg;

    localparam int DATA_W          = 32;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int CNT_W           = 3;
    localparam int IDX_W           = 3;
    localparam int MAX_TERMS_DEF   = 7;
    localparam int FRAC_BITS_DEF   = 16;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_TERM_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_BASE  = 3'd1;

    localparam logic [CNT_W-1:0] TERM_COUNT_RST = 3'd7;

    localparam logic signed [PROD_W-1:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

    // one pipeline slot
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] power;
        logic signed [DATA_W-1:0] sum;
        logic                     ovf;
    } ppse_lane_t;

    function automatic logic sat_hit_w(input logic signed [PROD_W-1:0] v);
        return (v > S32_MAX_W) || (v < S32_MIN_W);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX_W) begin
            r = S32_MAX_W[DATA_W-1:0];
        end else if (v < S32_MIN_W) begin
            r = S32_MIN_W[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // sign-extended sum of two 32-bit values; add_sat saturates it to 32 bits
    function automatic logic signed [DATA_W:0] add_ext(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        return {a[DATA_W-1], a} + {b[DATA_W-1], b};
    endfunction

    function automatic logic add_hit(input logic signed [DATA_W:0] s);
        return s[DATA_W] != s[DATA_W-1];
    endfunction

    function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W:0] s);
        logic signed [DATA_W-1:0] r;
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? S32_MIN_W[DATA_W-1:0] : S32_MAX_W[DATA_W-1:0];
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/polynomial_power_series_eval.sv =====
// ----------------------------------------------------------------------------
// polynomial_power_series_eval
// Pipeline: two register stages per term: multiply, accumulate.
// Throughput: one word per cycle; the whole chain advances together and holds
//   while a result waits on m_tready.
// Reset: synchronous, active low; clears valid bits, term_count to 7, coefs 0.
// ----------------------------------------------------------------------------
module polynomial_power_series_eval #(
    parameter int MAX_TERMS = ppse_pkg::MAX_TERMS_DEF,  // 1..7
    parameter int FRAC_BITS = ppse_pkg::FRAC_BITS_DEF   // 0..30
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppse_pkg::DATA_W-1:0]      s_tdata,   // [31:0] sample_x
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppse_pkg::DATA_W-1:0]      m_tdata,   // [31:0] poly_value
    output logic [0:0]                       m_tuser,   // [0] overflow
    // config write port
    input  logic                             cfg_wr_en,
    input  logic [ppse_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ppse_pkg::DATA_W-1:0]      cfg_wdata
);
    import ppse_pkg::*;

    // 1.0 in the working Q format, seed of the power chain
    localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] coef [MAX_TERMS];
    logic [MAX_TERMS-1:0]     term_active;
    logic [MAX_TERMS-1:0]     pow_active;
    ppse_lane_t               lane [MAX_TERMS+1];
    logic                     advance;

    ppse_cfg_regs #(
        .MAX_TERMS (MAX_TERMS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .coef        (coef),
        .term_active (term_active),
        .pow_active  (pow_active)
    );

    // Pipeline moves as one unit; it stops only when the final stage holds a
    // word that the sink is not taking. Empty slots travel as bubbles.
    assign advance  = !lane[MAX_TERMS].valid || m_tready;
    assign s_tready = advance;

    // entry slot: power starts at 1.0, sum at 0
    assign lane[0] = '{valid: s_tvalid, x: s_tdata, power: ONE_Q, sum: '0, ovf: 1'b0};

    // one term per stage pair; inactive terms pass the sum through, so a
    // term count of zero gives 0 with no overflow
    for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
        ppse_term_stage #(
            .FRAC_BITS (FRAC_BITS)
        ) u_term (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (advance),
            .term_active (term_active[k]),
            .pow_active  (pow_active[k]),
            .coef        (coef[k]),
            .lane_in     (lane[k]),
            .lane_out    (lane[k+1])
        );
    end

    // the last accumulate register is the output register
    assign m_tvalid   = lane[MAX_TERMS].valid;
    assign m_tdata    = lane[MAX_TERMS].sum;
    assign m_tuser[0] = lane[MAX_TERMS].ovf;

`ifndef SYNTHESIS
    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stall freezes the first term stage
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && lane[1].valid) |=>
            (lane[1].valid && $stable(lane[1].sum) && $stable(lane[1].power)))
        else $error("first stage changed during stall");

    // input ready is high exactly when the last stage is empty or its word is taken
    a_ready_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");
`endif

endmodule

// ===== src/ppse_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppse_cfg_regs
// Term count and coefficient registers, plus per-stage enables.
// ----------------------------------------------------------------------------
module ppse_cfg_regs #(
    parameter int MAX_TERMS = ppse_pkg::MAX_TERMS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ppse_pkg::IDX_W-1:0]            cfg_index,
    input  logic [ppse_pkg::DATA_W-1:0]           cfg_wdata,
    output logic signed [ppse_pkg::DATA_W-1:0]    coef [MAX_TERMS],
    output logic [MAX_TERMS-1:0]                  term_active,
    output logic [MAX_TERMS-1:0]                  pow_active
);
    import ppse_pkg::*;

    logic [CNT_W-1:0]         term_count_reg;
    logic signed [DATA_W-1:0] coef_reg [MAX_TERMS];
    logic [CNT_W-1:0]         n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= TERM_COUNT_RST;
            for (int i = 0; i < MAX_TERMS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_TERM_COUNT) begin
                term_count_reg <= cfg_wdata[CNT_W-1:0];
            end
            for (int i = 0; i < MAX_TERMS; i++) begin
                if (cfg_index == REG_COEF_BASE + IDX_W'(i)) begin
                    coef_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // clamp to the number of built stages
    assign n_eff = (int'(term_count_reg) > MAX_TERMS) ? CNT_W'(MAX_TERMS) : term_count_reg;

    always_comb begin
        for (int k = 0; k < MAX_TERMS; k++) begin
            term_active[k] = k < int'(n_eff);
            pow_active[k]  = (k + 1) < int'(n_eff);
            coef[k]        = coef_reg[k];
        end
    end

endmodule

// ===== src/ppse_term_stage.sv =====
// ----------------------------------------------------------------------------
// ppse_term_stage
// One term: multiply stage, then shift/saturate/accumulate stage.
// ----------------------------------------------------------------------------
module ppse_term_stage #(
    parameter int FRAC_BITS = ppse_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               term_active,
    input  logic                               pow_active,
    input  logic signed [ppse_pkg::DATA_W-1:0] coef,
    input  ppse_pkg::ppse_lane_t               lane_in,
    output ppse_pkg::ppse_lane_t               lane_out
);
    import ppse_pkg::*;

    // multiply stage
    logic                     a_valid_reg;
    logic signed [DATA_W-1:0] a_x_reg;
    logic signed [DATA_W-1:0] a_power_reg;
    logic signed [DATA_W-1:0] a_sum_reg;
    logic                     a_ovf_reg;
    logic signed [PROD_W-1:0] a_pterm_reg;
    logic signed [PROD_W-1:0] a_ppow_reg;
    logic signed [PROD_W-1:0] a_pterm_next;
    logic signed [PROD_W-1:0] a_ppow_next;

    // accumulate stage
    ppse_lane_t               b_lane_reg;
    ppse_lane_t               b_lane_next;
    logic signed [PROD_W-1:0] term_w;
    logic signed [PROD_W-1:0] pow_w;
    logic signed [DATA_W-1:0] term_s;
    logic signed [DATA_W:0]   sum_ext;

    assign a_pterm_next = PROD_W'(coef) * PROD_W'(lane_in.power);
    assign a_ppow_next  = PROD_W'(lane_in.power) * PROD_W'(lane_in.x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= lane_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg     <= lane_in.x;
            a_power_reg <= lane_in.power;
            a_sum_reg   <= lane_in.sum;
            a_ovf_reg   <= lane_in.ovf;
            a_pterm_reg <= a_pterm_next;
            a_ppow_reg  <= a_ppow_next;
        end
    end

    // arithmetic shift floors toward minus infinity
    assign term_w  = a_pterm_reg >>> FRAC_BITS;
    assign pow_w   = a_ppow_reg >>> FRAC_BITS;
    assign term_s  = sat_w(term_w);
    assign sum_ext = add_ext(a_sum_reg, term_s);

    always_comb begin
        b_lane_next       = '0;
        b_lane_next.valid = a_valid_reg;
        b_lane_next.x     = a_x_reg;
        b_lane_next.power = a_power_reg;
        b_lane_next.sum   = a_sum_reg;
        b_lane_next.ovf   = a_ovf_reg;
        if (term_active) begin
            b_lane_next.sum = add_sat(sum_ext);
            b_lane_next.ovf = a_ovf_reg | sat_hit_w(term_w) | add_hit(sum_ext)
                              | (pow_active & sat_hit_w(pow_w));
        end
        if (pow_active) begin
            b_lane_next.power = sat_w(pow_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_lane_reg <= '0;
        end else if (en) begin
            b_lane_reg <= b_lane_next;
        end
    end

    assign lane_out = b_lane_reg;

endmodule
